// File: sv/tlptb_pkg.sv
package tlptb_pkg;

   localparam int TABLE_PAGES = 16;
   localparam int WORDS_PER_PAGE = 1024;
   localparam int IDX_W = 10;
   localparam int PAGE_W = $clog2(TABLE_PAGES);
   localparam int NEXT_W = $clog2(TABLE_PAGES + 1);
   localparam int ADDR_W = PAGE_W + IDX_W;
   localparam int STORE_WORDS = TABLE_PAGES * WORDS_PER_PAGE;
   localparam int PN_W = 20;

   localparam logic [11:0] ENTRY_FLAGS = 12'h003;
   localparam logic [IDX_W-1:0] RECURSIVE_SLOT = IDX_W'(1023);
   localparam logic [31:0] PAGE_ROUND = 32'h0000_0FFF;

   localparam logic CSR_TABLE_BASE_ADDRESS = 1'b0;
   localparam logic CSR_VIRTUAL_OFFSET = 1'b1;

   localparam logic [PN_W-1:0] RESET_BASE_PAGE = 20'h00100;
   localparam logic [PN_W-1:0] RESET_OFFSET_PAGE = 20'hC0000;

   typedef enum logic [1:0] {
      KIND_MAP_OFFSET = 2'd0,
      KIND_MAP_IDENTITY = 2'd1,
      KIND_RECURSIVE = 2'd2,
      KIND_READ_WORD = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      MEM_NONE,
      MEM_READ_DIR,
      MEM_READ_WORD,
      MEM_WRITE_RECURSIVE,
      MEM_CLEAR_DIR,
      MEM_CLEAR_PAGE,
      MEM_LINK,
      MEM_WRITE_ENTRY
   } mem_op_type;

   typedef struct packed {
      logic load_req;
      mem_op_type mem_op;
      logic take_dir_entry;
      logic allocate;
      logic set_exhausted;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic exhausted;
      logic range_done;
      logic dir_present;
      logic pages_left;
      logic clear_last;
   } dp_status_type;

endpackage

// File: sv/tlptb_ctrl.sv
module tlptb_ctrl
   import tlptb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR_DIR,
      ST_IDLE,
      ST_DISPATCH,
      ST_LOOP,
      ST_CHECK,
      ST_CLEAR_PAGE,
      ST_LINK,
      ST_WRITE_ENTRY,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.mem_op = MEM_NONE;
      case (state_ff)
         ST_CLEAR_DIR: begin
            cmd.mem_op = MEM_CLEAR_DIR;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (status.kind)
               KIND_MAP_OFFSET, KIND_MAP_IDENTITY: begin
                  state_in = status.exhausted ? ST_FINISH : ST_LOOP;
               end
               KIND_RECURSIVE: begin
                  cmd.mem_op = MEM_WRITE_RECURSIVE;
                  state_in = ST_FINISH;
               end
               KIND_READ_WORD: begin
                  cmd.mem_op = MEM_READ_WORD;
                  state_in = ST_FINISH;
               end
               default: state_in = ST_FINISH;
            endcase
         end
         ST_LOOP: begin
            if (status.range_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.mem_op = MEM_READ_DIR;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.dir_present) begin
               cmd.take_dir_entry = 1'b1;
               state_in = ST_WRITE_ENTRY;
            end else if (!status.pages_left) begin
               cmd.set_exhausted = 1'b1;
               state_in = ST_FINISH;
            end else begin
               cmd.allocate = 1'b1;
               state_in = ST_CLEAR_PAGE;
            end
         end
         ST_CLEAR_PAGE: begin
            cmd.mem_op = MEM_CLEAR_PAGE;
            if (status.clear_last) begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            cmd.mem_op = MEM_LINK;
            state_in = ST_WRITE_ENTRY;
         end
         ST_WRITE_ENTRY: begin
            cmd.mem_op = MEM_WRITE_ENTRY;
            state_in = ST_LOOP;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR_DIR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: sv/tlptb_datapath.sv
module tlptb_datapath
   import tlptb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [1:0]    req_kind,
   input  logic [31:0]   req_range_start,
   input  logic [31:0]   req_range_end,
   input  logic [13:0]   req_word_address,
   input  logic          csr_write_enable,
   input  logic          csr_index,
   input  logic [31:0]   csr_write_data,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          rsp_status,
   output logic [31:0]   rsp_table_end_address,
   output logic [31:0]   rsp_read_word
);

   logic [31:0] mem [0:STORE_WORDS-1];

   logic [PN_W-1:0] base_pg_ff, base_pg_in;
   logic [PN_W-1:0] off_pg_ff, off_pg_in;
   kind_type kind_ff, kind_in;
   logic [PN_W-1:0] a_pg_ff, a_pg_in;
   logic [PN_W-1:0] end_pg_ff, end_pg_in;
   logic [13:0] waddr_ff, waddr_in;
   logic [NEXT_W-1:0] next_ff, next_in;
   logic exhausted_ff, exhausted_in;
   logic [IDX_W-1:0] clear_cnt_ff, clear_cnt_in;
   logic [PAGE_W-1:0] alloc_page_ff, alloc_page_in;
   logic [PN_W-1:0] dir_pg_ff, dir_pg_in;
   logic [31:0] rdata_ff;
   logic rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_tea_ff, rsp_tea_in;
   logic [31:0] rsp_word_ff, rsp_word_in;

   logic [31:0] end_sum;
   logic [PN_W-1:0] va_pg;
   logic [IDX_W-1:0] dir_idx;
   logic [IDX_W-1:0] tab_idx;
   logic [PN_W-1:0] link_pg;
   logic [PN_W-1:0] entry_pg;
   logic entry_ok;
   logic word_ok;
   logic mem_rd;
   logic mem_wr;
   logic [ADDR_W-1:0] mem_addr;
   logic [31:0] mem_wdata;

   assign end_sum = req_range_end + PAGE_ROUND;
   assign va_pg = (kind_ff == KIND_MAP_OFFSET) ? a_pg_ff + off_pg_ff : a_pg_ff;
   assign dir_idx = va_pg[PN_W-1:IDX_W];
   assign tab_idx = va_pg[IDX_W-1:0];
   assign link_pg = base_pg_ff + PN_W'(alloc_page_ff);
   assign entry_pg = dir_pg_ff - base_pg_ff;
   assign entry_ok = (32'(entry_pg) < 32'(TABLE_PAGES));
   assign word_ok = (32'(waddr_ff[13:IDX_W]) < 32'(TABLE_PAGES));

   always_comb begin
      mem_rd = 1'b0;
      mem_wr = 1'b0;
      mem_addr = '0;
      mem_wdata = '0;
      case (cmd.mem_op)
         MEM_READ_DIR: begin
            mem_rd = 1'b1;
            mem_addr = {PAGE_W'(0), dir_idx};
         end
         MEM_READ_WORD: begin
            mem_rd = word_ok;
            mem_addr = ADDR_W'(waddr_ff);
         end
         MEM_WRITE_RECURSIVE: begin
            mem_wr = 1'b1;
            mem_addr = {PAGE_W'(0), RECURSIVE_SLOT};
            mem_wdata = {base_pg_ff, ENTRY_FLAGS};
         end
         MEM_CLEAR_DIR: begin
            mem_wr = 1'b1;
            mem_addr = {PAGE_W'(0), clear_cnt_ff};
         end
         MEM_CLEAR_PAGE: begin
            mem_wr = 1'b1;
            mem_addr = {alloc_page_ff, clear_cnt_ff};
         end
         MEM_LINK: begin
            mem_wr = 1'b1;
            mem_addr = {PAGE_W'(0), dir_idx};
            mem_wdata = {link_pg, ENTRY_FLAGS};
         end
         MEM_WRITE_ENTRY: begin
            mem_wr = entry_ok;
            mem_addr = {entry_pg[PAGE_W-1:0], tab_idx};
            mem_wdata = {a_pg_ff, ENTRY_FLAGS};
         end
         MEM_NONE: begin
            mem_rd = 1'b0;
         end
         default: begin
            mem_rd = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_rd) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   always_comb begin
      base_pg_in = base_pg_ff;
      off_pg_in = off_pg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_TABLE_BASE_ADDRESS: base_pg_in = csr_write_data[31:12];
            CSR_VIRTUAL_OFFSET: off_pg_in = csr_write_data[31:12];
            default: base_pg_in = base_pg_ff;
         endcase
      end
   end

   always_comb begin
      kind_in = kind_ff;
      a_pg_in = a_pg_ff;
      end_pg_in = end_pg_ff;
      waddr_in = waddr_ff;
      if (cmd.load_req) begin
         kind_in = kind_type'(req_kind);
         a_pg_in = req_range_start[31:12];
         end_pg_in = end_sum[31:12];
         waddr_in = req_word_address;
      end else if (cmd.mem_op == MEM_WRITE_ENTRY) begin
         a_pg_in = a_pg_ff + PN_W'(1);
      end
   end

   always_comb begin
      next_in = next_ff;
      alloc_page_in = alloc_page_ff;
      exhausted_in = exhausted_ff || cmd.set_exhausted;
      clear_cnt_in = clear_cnt_ff;
      dir_pg_in = dir_pg_ff;
      if (cmd.allocate) begin
         next_in = next_ff + NEXT_W'(1);
         alloc_page_in = next_ff[PAGE_W-1:0];
      end
      if (cmd.mem_op == MEM_CLEAR_DIR || cmd.mem_op == MEM_CLEAR_PAGE) begin
         clear_cnt_in = clear_cnt_ff + IDX_W'(1);
      end
      if (cmd.take_dir_entry) begin
         dir_pg_in = rdata_ff[31:12];
      end else if (cmd.mem_op == MEM_LINK) begin
         dir_pg_in = link_pg;
      end
   end

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_tea_in = rsp_tea_ff;
      rsp_word_in = rsp_word_ff;
      if (cmd.load_rsp) begin
         rsp_status_in = exhausted_ff;
         rsp_tea_in = {base_pg_ff + PN_W'(next_ff), 12'h000};
         rsp_word_in = (kind_ff == KIND_READ_WORD && word_ok) ? rdata_ff : 32'h0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_pg_ff <= RESET_BASE_PAGE;
         off_pg_ff <= RESET_OFFSET_PAGE;
         next_ff <= NEXT_W'(1);
         exhausted_ff <= 1'b0;
         clear_cnt_ff <= '0;
      end else begin
         base_pg_ff <= base_pg_in;
         off_pg_ff <= off_pg_in;
         next_ff <= next_in;
         exhausted_ff <= exhausted_in;
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      a_pg_ff <= a_pg_in;
      end_pg_ff <= end_pg_in;
      waddr_ff <= waddr_in;
      alloc_page_ff <= alloc_page_in;
      dir_pg_ff <= dir_pg_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tea_ff <= rsp_tea_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign status.kind = kind_ff;
   assign status.exhausted = exhausted_ff;
   assign status.range_done = !(a_pg_ff < end_pg_ff);
   assign status.dir_present = rdata_ff[0];
   assign status.pages_left = (next_ff < NEXT_W'(TABLE_PAGES));
   assign status.clear_last = &clear_cnt_ff;

   assign rsp_status = rsp_status_ff;
   assign rsp_table_end_address = rsp_tea_ff;
   assign rsp_read_word = rsp_word_ff;

endmodule

// File: sv/two_level_page_table_builder.sv
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   kind, range_start, range_end, word_address
// rsp      out        rsp_valid/rsp_stall   status, table_end_address, read_word
// csr      in         csr_write_enable      csr_index, csr_write_data
//
// One transaction at a time; the table store is single-port. A map request walks its
// pages: it reads the directory entry, on a miss clears and links a new table page, then
// writes the table entry. After reset the directory page is zeroed with req_stall high.
// A finished result waits in the output register while the next request is taken.
module two_level_page_table_builder
   import tlptb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_range_start,
   input  logic [31:0] req_range_end,
   input  logic [13:0] req_word_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [31:0] rsp_table_end_address,
   output logic [31:0] rsp_read_word,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data
);

   dp_cmd_type cmd;
   dp_status_type status;

   tlptb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tlptb_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .req_kind              (req_kind),
      .req_range_start       (req_range_start),
      .req_range_end         (req_range_end),
      .req_word_address      (req_word_address),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .cmd                   (cmd),
      .status                (status),
      .rsp_status            (rsp_status),
      .rsp_table_end_address (rsp_table_end_address),
      .rsp_read_word         (rsp_read_word)
   );

endmodule
